FILE: rtl/bfk_pkg.sv
// package for the brute force k-nearest-neighbor search block
// types, sizes and state codes used by the controller, datapath and top level; no dependencies
`default_nettype none
package bfk_pkg;

    localparam int MaxBase = 1024;
    localparam int MaxDim = 128;
    localparam int MaxK = 64;
    localparam int CompBits = 16;
    localparam int StoreDepth = MaxBase * MaxDim;
    localparam int StoreAw = $clog2(StoreDepth);
    localparam int DimAw = $clog2(MaxDim);
    localparam int BaseIw = $clog2(MaxBase);
    localparam int KAw = $clog2(MaxK);
    localparam int DistBits = 39;
    localparam int DiffBits = CompBits + 1;
    localparam int SqBits = 2 * CompBits;
    localparam logic [DistBits-1:0] DistMax = {DistBits{1'b1}};

    localparam logic [1:0] RegDim = 2'd0;
    localparam logic [1:0] RegBase = 2'd1;
    localparam logic [1:0] RegK = 2'd2;

    typedef struct packed {
        logic                       req_type;
        logic signed [CompBits-1:0] component_value;
    } in_item_t;

    typedef struct packed {
        logic [5:0]          neighbor_rank;
        logic [9:0]          neighbor_index;
        logic [DistBits-1:0] neighbor_distance;
        logic                found;
        logic                last_of_query;
    } out_item_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_DIST,
        ST_DRAIN,
        ST_SCAN,
        ST_SHIFT,
        ST_EMIT_RD,
        ST_EMIT_WAIT,
        ST_EMIT
    } state_t;

    // commands from controller to datapath
    typedef struct packed {
        logic load_base;
        logic load_query;
        logic clr_best;
        logic dist_start;
        logic dist_step;
        logic dist_done;
        logic scan_start;
        logic scan_step;
        logic shift_step;
        logic insert;
        logic emit_start;
        logic emit_step;
        logic emit_latch;
        logic emit_read;
    } cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic last_query;
        logic clr_last;
        logic dim_last;
        logic base_last;
        logic better;
        logic scan_found;
        logic shift_last;
        logic emit_last;
    } stat_t;

endpackage
`default_nettype wire

FILE: rtl/bfk_ram.sv
// generic simple dual port ram (one write port, one read port) with registered read
// no dependencies
`default_nettype none
module bfk_ram #(
    parameter int Width = 16,
    parameter int Depth = 128
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(Depth)-1:0] waddr,
    input  wire logic [Width-1:0]         wdata,
    input  wire logic [$clog2(Depth)-1:0] raddr,
    output logic [Width-1:0]              rdata
);

    logic [Width-1:0] mem [Depth];

    // write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

FILE: rtl/bfk_ctrl.sv
// controller state machine of the k-nearest-neighbor search
// depends on bfk_pkg
`default_nettype none
module bfk_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_fire,
    input  wire logic           in_query,
    input  wire logic           out_free,
    input  wire bfk_pkg::stat_t stat,
    output bfk_pkg::cmd_t       cmd,
    output logic                in_ready
);

    bfk_pkg::state_t state_reg, state_next;
    logic [2:0] drain_reg, drain_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bfk_pkg::ST_IDLE;
            drain_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            drain_reg <= drain_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        drain_next = drain_reg;
        unique case (state_reg)
            bfk_pkg::ST_IDLE:
            begin
                if (in_fire && in_query && stat.last_query)
                begin
                    state_next = bfk_pkg::ST_CLEAR;
                end
            end
            bfk_pkg::ST_CLEAR:
            begin
                if (stat.clr_last)
                begin
                    state_next = bfk_pkg::ST_DIST;
                end
            end
            bfk_pkg::ST_DIST:
            begin
                if (stat.dim_last)
                begin
                    state_next = bfk_pkg::ST_DRAIN;
                    drain_next = 3'd4;
                end
            end
            bfk_pkg::ST_DRAIN:
            begin
                drain_next = drain_reg - 3'd1;
                if (drain_reg == 3'd0)
                begin
                    state_next = stat.better ? bfk_pkg::ST_SCAN
                        : (stat.base_last ? bfk_pkg::ST_EMIT_RD : bfk_pkg::ST_DIST);
                end
            end
            bfk_pkg::ST_SCAN:
            begin
                if (stat.scan_found)
                begin
                    state_next = bfk_pkg::ST_SHIFT;
                end
            end
            bfk_pkg::ST_SHIFT:
            begin
                if (stat.shift_last)
                begin
                    state_next = stat.base_last ? bfk_pkg::ST_EMIT_RD : bfk_pkg::ST_DIST;
                end
            end
            bfk_pkg::ST_EMIT_RD:
            begin
                state_next = bfk_pkg::ST_EMIT_WAIT;
            end
            bfk_pkg::ST_EMIT_WAIT:
            begin
                if (out_free)
                begin
                    state_next = bfk_pkg::ST_EMIT;
                end
            end
            bfk_pkg::ST_EMIT:
            begin
                state_next = stat.emit_last ? bfk_pkg::ST_IDLE : bfk_pkg::ST_EMIT_WAIT;
            end
            default:
            begin
                state_next = bfk_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        cmd = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            bfk_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load_base = in_fire && !in_query;
                cmd.load_query = in_fire && in_query;
                cmd.dist_start = in_fire && in_query && stat.last_query;
            end
            bfk_pkg::ST_CLEAR:
            begin
                cmd.clr_best = 1'b1;
            end
            bfk_pkg::ST_DIST:
            begin
                cmd.dist_step = 1'b1;
            end
            bfk_pkg::ST_DRAIN:
            begin
                cmd.dist_done = (drain_reg == 3'd0);
                cmd.scan_start = (drain_reg == 3'd0);
            end
            bfk_pkg::ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
            end
            bfk_pkg::ST_SHIFT:
            begin
                cmd.shift_step = 1'b1;
                cmd.insert = stat.shift_last;
            end
            bfk_pkg::ST_EMIT_RD:
            begin
                cmd.emit_start = 1'b1;
                cmd.emit_read = 1'b1;
            end
            bfk_pkg::ST_EMIT_WAIT:
            begin
                cmd.emit_latch = out_free;
                cmd.emit_read = 1'b1;
            end
            bfk_pkg::ST_EMIT:
            begin
                cmd.emit_step = 1'b1;
                cmd.emit_read = 1'b1;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule
`default_nettype wire

FILE: rtl/bfk_dp.sv
// datapath: base store, query buffer, distance mac, best list, result register
// depends on bfk_pkg and bfk_ram
`default_nettype none
module bfk_dp (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire bfk_pkg::in_item_t in_item,
    input  wire bfk_pkg::cmd_t     cmd,
    input  wire logic [7:0]        dim_raw,
    input  wire logic [10:0]       base_raw,
    input  wire logic [6:0]        k_raw,
    output bfk_pkg::stat_t         stat,
    output bfk_pkg::out_item_t     out_item,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic                   out_free
);

    localparam int DimW = bfk_pkg::DimAw + 1;
    localparam int BaseW = bfk_pkg::BaseIw + 1;
    localparam int KW = bfk_pkg::KAw + 1;
    localparam int BestW = bfk_pkg::DistBits + 1 + bfk_pkg::BaseIw;

    // clamped register values
    logic [DimW-1:0]  dim;
    logic [BaseW-1:0] nb;
    logic [KW-1:0]    kk;
    logic [bfk_pkg::StoreAw:0] limit;

    always_comb
    begin
        if (dim_raw == 8'd0)
            dim = DimW'(1);
        else if (dim_raw > 8'(bfk_pkg::MaxDim))
            dim = DimW'(bfk_pkg::MaxDim);
        else
            dim = DimW'(dim_raw);
        if (base_raw == 11'd0)
            nb = BaseW'(1);
        else if (base_raw > 11'(bfk_pkg::MaxBase))
            nb = BaseW'(bfk_pkg::MaxBase);
        else
            nb = BaseW'(base_raw);
        if (k_raw == 7'd0)
            kk = KW'(1);
        else if (k_raw > 7'(bfk_pkg::MaxK))
            kk = KW'(bfk_pkg::MaxK);
        else
            kk = KW'(k_raw);
    end

    logic [bfk_pkg::StoreAw:0] lim_mul;
    assign lim_mul = (bfk_pkg::StoreAw + 1)'(nb) * (bfk_pkg::StoreAw + 1)'(dim);
    assign limit = lim_mul;

    // pointers
    logic [bfk_pkg::StoreAw:0] lp_reg, lp_next, lp_use;
    logic [DimW-1:0] qp_reg, qp_next, qp_use;

    assign lp_use = (lp_reg >= limit) ? '0 : lp_reg;
    assign qp_use = (qp_reg >= dim) ? '0 : qp_reg;
    assign stat.last_query = (qp_use + DimW'(1)) >= dim;

    always_comb
    begin
        lp_next = lp_reg;
        qp_next = qp_reg;
        if (cmd.load_base)
        begin
            lp_next = ((lp_use + 1'b1) >= limit) ? '0 : lp_use + 1'b1;
        end
        if (cmd.load_query)
        begin
            qp_next = stat.last_query ? '0 : qp_use + DimW'(1);
        end
    end

    // distance walk counters
    logic [bfk_pkg::StoreAw-1:0] addr_reg, addr_next;
    logic [DimW-1:0]  d_reg, d_next;
    logic [BaseW-1:0] b_reg, b_next;

    assign stat.dim_last = (d_reg + DimW'(1)) == dim;
    assign stat.base_last = (b_reg + BaseW'(1)) == nb;

    always_comb
    begin
        addr_next = addr_reg;
        d_next = d_reg;
        b_next = b_reg;
        if (cmd.dist_start)
        begin
            addr_next = '0;
            d_next = '0;
            b_next = '0;
        end
        else if (cmd.dist_step)
        begin
            addr_next = addr_reg + 1'b1;
            d_next = stat.dim_last ? '0 : d_reg + DimW'(1);
        end
        if (cmd.insert || (cmd.dist_done && !stat.better))
        begin
            b_next = b_reg + BaseW'(1);
        end
    end

    // memories
    logic [bfk_pkg::CompBits-1:0] base_rd, query_rd;

    bfk_ram #(
        .Width (bfk_pkg::CompBits),
        .Depth (bfk_pkg::StoreDepth)
    ) u_base (
        .clk   (clk),
        .we    (cmd.load_base),
        .waddr (lp_use[bfk_pkg::StoreAw-1:0]),
        .wdata (in_item.component_value),
        .raddr (addr_reg),
        .rdata (base_rd)
    );

    bfk_ram #(
        .Width (bfk_pkg::CompBits),
        .Depth (bfk_pkg::MaxDim)
    ) u_query (
        .clk   (clk),
        .we    (cmd.load_query),
        .waddr (qp_use[bfk_pkg::DimAw-1:0]),
        .wdata (in_item.component_value),
        .raddr (d_reg[bfk_pkg::DimAw-1:0]),
        .rdata (query_rd)
    );

    // mac pipeline: read, difference, square, accumulate
    logic v0_reg, v1_reg, v2_reg;
    logic signed [bfk_pkg::DiffBits-1:0] diff_reg;
    logic [bfk_pkg::SqBits-1:0] sq_reg;
    logic [bfk_pkg::DistBits:0] acc_reg, acc_next;
    logic [bfk_pkg::DiffBits-1:0] mag;

    assign mag = diff_reg[bfk_pkg::DiffBits-1] ? bfk_pkg::DiffBits'(-diff_reg)
                                               : bfk_pkg::DiffBits'(diff_reg);

    always_comb
    begin
        acc_next = acc_reg;
        if (cmd.dist_start || cmd.dist_done)
        begin
            acc_next = '0;
        end
        else if (v2_reg)
        begin
            acc_next = acc_reg + (bfk_pkg::DistBits + 1)'(sq_reg);
            if (acc_next > (bfk_pkg::DistBits + 1)'(bfk_pkg::DistMax))
                acc_next = (bfk_pkg::DistBits + 1)'(bfk_pkg::DistMax);
        end
    end

    always_ff @(posedge clk)
    begin
        diff_reg <= bfk_pkg::DiffBits'($signed(query_rd)) - bfk_pkg::DiffBits'($signed(base_rd));
        sq_reg <= bfk_pkg::SqBits'(mag * mag);
    end

    // candidate distance and best list, one ram entry per rank: {distance, index}
    logic [BestW-1:0] best_rd, best_wdata;
    logic [bfk_pkg::KAw-1:0] best_raddr, best_waddr;
    logic best_we;
    logic [bfk_pkg::DistBits:0] best_rd_d;
    logic [bfk_pkg::BaseIw-1:0] best_rd_i;
    logic [bfk_pkg::DistBits:0] cand;
    logic [bfk_pkg::DistBits:0] cand_reg;
    logic [KW-1:0] p_reg, p_next, q_reg, q_next;
    logic [KW-1:0] clr_reg;

    assign best_rd_d = best_rd[BestW-1:bfk_pkg::BaseIw];
    assign best_rd_i = best_rd[bfk_pkg::BaseIw-1:0];

    // accumulator is final at the done cycle, held in cand_reg afterwards
    assign cand = cmd.dist_done ? acc_reg : cand_reg;
    assign stat.better = cand < best_rd_d;
    assign stat.scan_found = (p_reg == kk - KW'(1)) || (cand < best_rd_d);
    assign stat.shift_last = (q_reg <= p_reg);
    assign stat.clr_last = (clr_reg == KW'(bfk_pkg::MaxK - 1));

    always_comb
    begin
        p_next = p_reg;
        q_next = q_reg;
        if (cmd.scan_start)
        begin
            p_next = '0;
        end
        else if (cmd.scan_step)
        begin
            if (stat.scan_found)
                q_next = kk - KW'(1);
            else
                p_next = p_reg + KW'(1);
        end
        else if (cmd.shift_step && !stat.shift_last)
        begin
            q_next = q_reg - KW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.dist_done)
        begin
            cand_reg <= acc_reg;
        end
    end

    // best list writes: clear pass, shift down by one rank, insert
    always_comb
    begin
        best_we = cmd.clr_best || cmd.shift_step;
        if (cmd.clr_best)
        begin
            best_waddr = bfk_pkg::KAw'(clr_reg);
            best_wdata = {{(bfk_pkg::DistBits + 1){1'b1}}, {bfk_pkg::BaseIw{1'b0}}};
        end
        else if (stat.shift_last)
        begin
            best_waddr = bfk_pkg::KAw'(p_reg);
            best_wdata = {cand_reg, bfk_pkg::BaseIw'(b_reg)};
        end
        else
        begin
            best_waddr = bfk_pkg::KAw'(q_reg);
            best_wdata = best_rd;
        end
    end

    bfk_ram #(
        .Width (BestW),
        .Depth (bfk_pkg::MaxK)
    ) u_best (
        .clk   (clk),
        .we    (best_we),
        .waddr (best_waddr),
        .wdata (best_wdata),
        .raddr (best_raddr),
        .rdata (best_rd)
    );

    // emit counter and output register
    logic [KW-1:0] r_reg, r_next;
    logic ov_reg, ov_next;
    bfk_pkg::out_item_t oi_reg, oi_next;
    logic [bfk_pkg::DistBits:0] sel_d;
    logic [bfk_pkg::BaseIw-1:0] sel_i;
    logic ok;

    assign sel_d = best_rd_d;
    assign sel_i = best_rd_i;
    assign ok = BaseW'(r_reg) < nb;
    assign stat.emit_last = (r_reg == kk - KW'(1));
    assign out_free = !ov_reg || out_ready;

    always_comb
    begin
        r_next = r_reg;
        ov_next = ov_reg && !out_ready;
        oi_next = oi_reg;
        if (cmd.emit_start)
        begin
            r_next = '0;
        end
        if (cmd.emit_latch)
        begin
            ov_next = 1'b1;
            oi_next.neighbor_rank = 6'(r_reg);
            oi_next.neighbor_index = ok ? 10'(sel_i) : '0;
            oi_next.neighbor_distance = ok ? bfk_pkg::DistBits'(sel_d) : '0;
            oi_next.found = ok;
            oi_next.last_of_query = stat.emit_last;
        end
        if (cmd.emit_step)
        begin
            r_next = r_reg + KW'(1);
        end
    end

    // best list read address, driven from the next rank so the registered ram output holds the rank in use
    always_comb
    begin
        if (cmd.shift_step || (cmd.scan_step && stat.scan_found))
            best_raddr = bfk_pkg::KAw'(q_next - KW'(1));
        else if (cmd.scan_start || cmd.scan_step)
            best_raddr = bfk_pkg::KAw'(p_next);
        else if (cmd.emit_read)
            best_raddr = bfk_pkg::KAw'(r_next);
        else
            best_raddr = bfk_pkg::KAw'(kk - KW'(1));
    end

    assign out_valid = ov_reg;
    assign out_item = oi_reg;

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lp_reg <= '0;
            qp_reg <= '0;
            addr_reg <= '0;
            d_reg <= '0;
            b_reg <= '0;
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            acc_reg <= '0;
            p_reg <= '0;
            q_reg <= '0;
            clr_reg <= '0;
            r_reg <= '0;
            ov_reg <= 1'b0;
        end
        else
        begin
            lp_reg <= lp_next;
            qp_reg <= qp_next;
            addr_reg <= (cmd.dist_done && !stat.base_last && !stat.better) ? addr_reg : addr_next;
            d_reg <= d_next;
            b_reg <= b_next;
            v0_reg <= cmd.dist_step;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
            acc_reg <= acc_next;
            p_reg <= p_next;
            q_reg <= q_next;
            clr_reg <= cmd.clr_best ? clr_reg + KW'(1) : '0;
            r_reg <= r_next;
            ov_reg <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        oi_reg <= oi_next;
    end

endmodule
`default_nettype wire

FILE: rtl/brute_force_knn_topk.sv
// exact k-nearest-neighbor search, top level: config registers, controller, datapath
// depends on bfk_pkg, bfk_ctrl, bfk_dp
// base loads and non-final query components are stored while the block stays idle
// final query component: clear pass over all 64 best list entries, then per base
// vector a mac pass over its components (one mac unit) and a drain, then a scan
// and shift if it enters the list; then neighbor_count results under back-pressure
// reset: asynchronous active low, registers return to 128 / 1024 / 10, pointers to zero
`default_nettype none
module brute_force_knn_topk (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire bfk_pkg::in_item_t  in_data,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output bfk_pkg::out_item_t      out_data,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [3:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);

    logic [7:0]  dim_reg;
    logic [10:0] base_reg;
    logic [6:0]  k_reg;
    logic [1:0]  ridx;

    assign ridx = paddr[3:2];
    assign pready = 1'b1;

    // config register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dim_reg <= 8'd128;
            base_reg <= 11'd1024;
            k_reg <= 7'd10;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (ridx)
                bfk_pkg::RegDim: dim_reg <= pwdata[7:0];
                bfk_pkg::RegBase: base_reg <= pwdata[10:0];
                bfk_pkg::RegK: k_reg <= pwdata[6:0];
                default: ;
            endcase
        end
    end

    // config register reads
    always_comb
    begin
        unique case (ridx)
            bfk_pkg::RegDim: prdata = {24'd0, dim_reg};
            bfk_pkg::RegBase: prdata = {21'd0, base_reg};
            bfk_pkg::RegK: prdata = {25'd0, k_reg};
            default: prdata = '0;
        endcase
    end

    bfk_pkg::cmd_t  cmd;
    bfk_pkg::stat_t stat;
    logic out_free;
    logic in_fire;

    assign in_fire = in_valid && in_ready;

    bfk_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_fire  (in_fire),
        .in_query (in_data.req_type),
        .out_free (out_free),
        .stat     (stat),
        .cmd      (cmd),
        .in_ready (in_ready)
    );

    bfk_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_item   (in_data),
        .cmd       (cmd),
        .dim_raw   (dim_reg),
        .base_raw  (base_reg),
        .k_raw     (k_reg),
        .stat      (stat),
        .out_item  (out_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_free  (out_free)
    );

endmodule
`default_nettype wire

FILE: tb/brute_force_knn_topk_test.sv
// self-checking testbench for the brute force k-nearest-neighbor search block
// depends on bfk_pkg and brute_force_knn_topk; predicts every result item in the testbench
`default_nettype none
module brute_force_knn_topk_test;

    localparam int WatchLimit = 20000;
    localparam logic [39:0] BestInit = {40{1'b1}};

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    bfk_pkg::in_item_t in_data = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    bfk_pkg::out_item_t out_data;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [3:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    brute_force_knn_topk i_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // pending items, expected neighbors and the shadow state of the search
    bfk_pkg::in_item_t pending_items[$];
    bfk_pkg::out_item_t neighbor_q[$];
    int errors = 0;
    int idle_mode = 0;
    logic in_fire = 1'b0;
    logic [7:0] dim_reg = 8'd128;
    logic [10:0] base_reg = 11'd1024;
    logic [6:0] k_reg = 7'd10;
    int base_mem[bfk_pkg::StoreDepth];
    int query_mem[bfk_pkg::MaxDim];
    int load_ptr = 0;
    int qbuf_pos = 0;

    // register value as the block reads it
    function automatic int clamp_reg(int v, int hi);
        if (v < 1) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    // shadow search: update stores, on the final query component rank all base vectors
    function automatic void search_neighbors(bfk_pkg::in_item_t it);
        int dim;
        int nb;
        int kk;
        int lim;
        int comp;
        int p;
        longint diff;
        longint sum;
        logic [39:0] best_d[bfk_pkg::MaxK];
        int best_i[bfk_pkg::MaxK];
        bfk_pkg::out_item_t e;
        dim = clamp_reg(dim_reg, bfk_pkg::MaxDim);
        nb = clamp_reg(base_reg, bfk_pkg::MaxBase);
        kk = clamp_reg(k_reg, bfk_pkg::MaxK);
        comp = $signed(it.component_value);
        if (it.req_type == 1'b0) begin
            lim = nb * dim;
            if (load_ptr >= lim) load_ptr = 0;
            base_mem[load_ptr] = comp;
            load_ptr++;
            if (load_ptr >= lim) load_ptr = 0;
            return;
        end
        if (qbuf_pos >= dim) qbuf_pos = 0;
        query_mem[qbuf_pos] = comp;
        qbuf_pos++;
        if (qbuf_pos < dim) return;
        qbuf_pos = 0;
        for (int r = 0; r < bfk_pkg::MaxK; r++)
        begin
            best_d[r] = BestInit;
            best_i[r] = 0;
        end
        for (int b = 0; b < nb; b++)
        begin
            sum = 0;
            for (int d = 0; d < dim; d++)
            begin
                diff = longint'(query_mem[d]) - longint'(base_mem[b * dim + d]);
                if (diff < 0) diff = -diff;
                sum += diff * diff;
                if (sum > longint'(bfk_pkg::DistMax)) sum = longint'(bfk_pkg::DistMax);
            end
            if (!(40'(sum) < best_d[kk-1])) continue;
            p = 0;
            while (p < kk - 1 && !(40'(sum) < best_d[p])) p++;
            for (int q = kk - 1; q > p; q--)
            begin
                best_d[q] = best_d[q-1];
                best_i[q] = best_i[q-1];
            end
            best_d[p] = 40'(sum);
            best_i[p] = b;
        end
        for (int r = 0; r < kk; r++)
        begin
            e.neighbor_rank = 6'(r);
            e.neighbor_index = (r < nb) ? 10'(best_i[r]) : 10'd0;
            e.neighbor_distance = (r < nb) ? best_d[r][bfk_pkg::DistBits-1:0] : '0;
            e.found = (r < nb);
            e.last_of_query = (r == kk - 1);
            neighbor_q.push_back(e);
        end
    endfunction

    // clock
    initial
    begin
        forever #2 clk = ~clk;
    end

    // driver: new item at the falling edge unless the current one is still waiting
    always @(negedge clk)
    begin
        if (in_valid && !in_fire) begin
            in_valid <= 1'b1;
        end else if (rst_n && pending_items.size() > 0 &&
                     !((idle_mode == 1 && $urandom_range(99) < 57) ||
                       (idle_mode == 3 && $urandom_range(99) < 23))) begin
            in_data <= pending_items.pop_front();
            in_valid <= 1'b1;
        end else begin
            in_valid <= 1'b0;
        end
        out_ready <= !((idle_mode == 2 && $urandom_range(99) < 57) ||
                       (idle_mode == 3 && $urandom_range(99) < 23));
    end

    // monitor: predict on accepted inputs, check accepted results, watchdog
    int quiet_cycles = 0;
    always @(posedge clk)
    begin
        in_fire <= in_valid && in_ready;
        if (in_valid && in_ready) search_neighbors(in_data);
        if (out_valid && out_ready) begin
            if (neighbor_q.size() == 0) begin
                $display("%0t: unexpected item %p", $time, out_data);
                errors++;
            end else begin
                bfk_pkg::out_item_t e;
                e = neighbor_q.pop_front();
                if (e.neighbor_rank !== out_data.neighbor_rank) begin
                    $display("%0t: rank exp %0d got %0d", $time,
                             e.neighbor_rank, out_data.neighbor_rank);
                    errors++;
                end
                if (e.neighbor_index !== out_data.neighbor_index) begin
                    $display("%0t: index exp %0d got %0d", $time,
                             e.neighbor_index, out_data.neighbor_index);
                    errors++;
                end
                if (e.neighbor_distance !== out_data.neighbor_distance) begin
                    $display("%0t: distance exp %0d got %0d", $time,
                             e.neighbor_distance, out_data.neighbor_distance);
                    errors++;
                end
                if (e.found !== out_data.found) begin
                    $display("%0t: found exp %0b got %0b", $time, e.found, out_data.found);
                    errors++;
                end
                if (e.last_of_query !== out_data.last_of_query) begin
                    $display("%0t: last exp %0b got %0b", $time,
                             e.last_of_query, out_data.last_of_query);
                    errors++;
                end
            end
        end
        if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WatchLimit) begin
            $display("watchdog expired at %0t", $time);
            $display("status: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // register write: setup then access cycle
    task automatic write_reg(logic [1:0] idx, logic [31:0] value);
        @(negedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        case (idx)
            bfk_pkg::RegDim: dim_reg = value[7:0];
            bfk_pkg::RegBase: base_reg = value[10:0];
            bfk_pkg::RegK: k_reg = value[6:0];
            default: ;
        endcase
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic set_search(int dim, int nb, int kk);
        write_reg(bfk_pkg::RegDim, dim);
        write_reg(bfk_pkg::RegBase, nb);
        write_reg(bfk_pkg::RegK, kk);
    endtask

    task automatic add_item(logic kind, logic [15:0] value);
        bfk_pkg::in_item_t it;
        it.req_type = kind;
        it.component_value = value;
        pending_items.push_back(it);
    endtask

    function automatic logic [15:0] rand_component();
        case ($urandom_range(7))
            0: return 16'h7fff;
            1: return 16'h8000;
            2: return 16'h0000;
            3: return 16'hffff;
            4: return 16'($urandom_range(7));
            default: return 16'($urandom);
        endcase
    endfunction

    // fill the whole base store in use so that no unwritten entry is ever read
    task automatic fill_base();
        int lim;
        lim = clamp_reg(dim_reg, bfk_pkg::MaxDim) * clamp_reg(base_reg, bfk_pkg::MaxBase);
        for (int i = 0; i < lim; i++)
            add_item(1'b0, rand_component());
    endtask

    // wait until nothing is pending or expected, then let the block settle
    task automatic wait_idle();
        while (pending_items.size() > 0 || in_valid || neighbor_q.size() > 0)
            @(posedge clk);
        repeat (16) @(posedge clk);
    endtask

    // stimulus
    initial
    begin
        int n;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: field extremes, ties between equal vectors, surplus ranks
        idle_mode = 0;
        set_search(2, 4, 6);
        add_item(1'b0, 16'h7fff); add_item(1'b0, 16'h8000);
        add_item(1'b0, 16'h0000); add_item(1'b0, 16'h0000);
        add_item(1'b0, 16'h0000); add_item(1'b0, 16'h0000);
        add_item(1'b0, 16'h8000); add_item(1'b0, 16'h7fff);
        add_item(1'b1, 16'h7fff); add_item(1'b1, 16'h8000);
        add_item(1'b1, 16'h8000); add_item(1'b1, 16'h7fff);
        add_item(1'b1, 16'h0000); add_item(1'b1, 16'h0000);
        wait_idle();

        // out-of-range writes clamp: dimension 1, most neighbors, many surplus ranks
        idle_mode = 2;
        set_search(0, 3, 127);
        fill_base();
        add_item(1'b1, rand_component());
        wait_idle();

        // zero neighbor count and zero base count read as one
        idle_mode = 1;
        write_reg(bfk_pkg::RegK, 0);
        write_reg(bfk_pkg::RegBase, 0);
        fill_base();
        add_item(1'b1, rand_component());
        wait_idle();

        // longer vectors with both sides idling
        idle_mode = 3;
        set_search(8, 2, 3);
        fill_base();
        for (int i = 0; i < 8; i++) add_item(1'b1, rand_component());
        wait_idle();

        // random phases with small sizes; stale pointers carry over between phases
        for (int ph = 0; ph < 4; ph++)
        begin
            idle_mode = ph % 4;
            set_search($urandom_range(1, 4), $urandom_range(1, 6), $urandom_range(1, 16));
            fill_base();
            n = 0;
            while (n < 8) begin
                if ($urandom_range(3) == 0) begin
                    add_item(1'b0, rand_component());
                end else begin
                    add_item(1'b1, rand_component());
                end
                n++;
            end
            wait_idle();
        end

        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
`default_nettype wire

FILE: brute_force_knn_topk.f
rtl/bfk_pkg.sv
rtl/bfk_ram.sv
rtl/bfk_ctrl.sv
rtl/bfk_dp.sv
rtl/brute_force_knn_topk.sv
tb/brute_force_knn_topk_test.sv
